>>> hw/rtl/sgdm_pkg.sv
package sgdm_pkg;

    localparam int VW    = 32;          // value width, signed Q16.16
    localparam int HPW   = 16;          // hyperparameter width, unsigned Q0.16
    localparam int FW    = HPW + 1;     // factor width, holds 1.0 exactly
    localparam int PW    = VW + 2;      // shifted product width
    localparam int SW    = VW + 3;      // pre-saturation sum width
    localparam int NSTG  = 8;           // pipeline stages
    localparam int IN_W  = ((3 * VW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * VW + 7) / 8) * 8;

    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_sum;
    typedef logic [HPW-1:0]       t_hp;
    typedef logic [FW-1:0]        t_fac;

    typedef enum logic [2:0] {
        CFG_LR    = 3'd0,
        CFG_WD    = 3'd1,
        CFG_MF    = 3'd2,
        CFG_DAMP  = 3'd3,
        CFG_MOM   = 3'd4,
        CFG_NEST  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_hp  lr;
        t_hp  wd;
        t_hp  mf;
        t_hp  damp;
        logic mom_en;
        logic nest_en;
    } t_cfg;

    typedef struct packed {
        logic [NSTG-1:0] vld;
        logic [NSTG-1:0] adv;
    } t_pipe_stat;

    localparam t_fac FAC_ONE = t_fac'(1) << HPW;
    localparam t_val VMAX    = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VMIN    = {1'b1, {(VW-1){1'b0}}};

    // floor(a * h / 2^HPW), exact
    function automatic t_prod mul_q16(t_val a, t_fac h);
        logic signed [VW+FW:0] p;
        p = a * $signed({1'b0, h});
        return p[VW+FW:HPW];
    endfunction

    function automatic t_val sat_val(t_sum x);
        t_val r;
        if (x > t_sum'(VMAX)) begin
            r = VMAX;
        end else if (x < t_sum'(VMIN)) begin
            r = VMIN;
        end else begin
            r = t_val'(x[VW-1:0]);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/sgdm_cfg.sv
module sgdm_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output sgdm_pkg::t_cfg o_cfg
);
    import sgdm_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LR:   r_cfg.lr      <= t_hp'(i_cfg_data);
                CFG_WD:   r_cfg.wd      <= t_hp'(i_cfg_data);
                CFG_MF:   r_cfg.mf      <= t_hp'(i_cfg_data);
                CFG_DAMP: r_cfg.damp    <= t_hp'(i_cfg_data);
                CFG_MOM:  r_cfg.mom_en  <= i_cfg_data[0];
                CFG_NEST: r_cfg.nest_en <= i_cfg_data[0];
                default:  ;  // writes past the map are dropped
            endcase
        end
    end

endmodule

>>> hw/rtl/sgdm_pipe.sv
module sgdm_pipe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sgdm_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  sgdm_pkg::t_val         i_weight,
    input  sgdm_pkg::t_val         i_gradient,
    input  sgdm_pkg::t_val         i_velocity,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sgdm_pkg::t_val         o_weight,
    output sgdm_pkg::t_val         o_velocity,
    output logic                   o_last,
    output sgdm_pkg::t_pipe_stat   o_stat
);
    import sgdm_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;
    logic            w_mom_on;
    t_fac            w_mf;
    t_fac            w_omd;

    // stage data
    t_val  r_s1_w, r_s1_g, r_s1_v;  t_prod r_s1_pwd, r_s1_pvm;
    t_val  r_s2_w, r_s2_v, r_s2_g1; t_prod r_s2_pvm;
    t_val  r_s3_w, r_s3_v, r_s3_g1; t_prod r_s3_pvm, r_s3_pgd;
    t_val  r_s4_w, r_s4_v, r_s4_g1, r_s4_v1;
    t_val  r_s5_w, r_s5_v, r_s5_g1, r_s5_v1; t_prod r_s5_pnm;
    t_val  r_s6_w, r_s6_vo, r_s6_g2;
    t_val  r_s7_w, r_s7_vo; t_prod r_s7_pl;
    t_val  r_s8_wo, r_s8_vo;
    logic [NSTG-1:0] r_last;

    assign w_mom_on = i_cfg.mom_en && (i_cfg.mf != '0);
    assign w_mf     = {1'b0, i_cfg.mf};
    assign w_omd    = FAC_ONE - {1'b0, i_cfg.damp};

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) r_last[0] <= i_last;
        for (int k = 1; k < NSTG; k++) begin
            if (w_adv[k]) r_last[k] <= r_last[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        // decay product, velocity momentum product
        if (w_adv[0]) begin
            r_s1_w   <= i_weight;
            r_s1_g   <= i_gradient;
            r_s1_v   <= i_velocity;
            r_s1_pwd <= mul_q16(i_weight, {1'b0, i_cfg.wd});
            r_s1_pvm <= mul_q16(i_velocity, w_mf);
        end
        // decayed gradient
        if (w_adv[1]) begin
            r_s2_w   <= r_s1_w;
            r_s2_v   <= r_s1_v;
            r_s2_pvm <= r_s1_pvm;
            r_s2_g1  <= sat_val(t_sum'(r_s1_g) + t_sum'(r_s1_pwd));
        end
        // dampened gradient product
        if (w_adv[2]) begin
            r_s3_w   <= r_s2_w;
            r_s3_v   <= r_s2_v;
            r_s3_g1  <= r_s2_g1;
            r_s3_pvm <= r_s2_pvm;
            r_s3_pgd <= mul_q16(r_s2_g1, w_omd);
        end
        // new velocity
        if (w_adv[3]) begin
            r_s4_w  <= r_s3_w;
            r_s4_v  <= r_s3_v;
            r_s4_g1 <= r_s3_g1;
            r_s4_v1 <= sat_val(t_sum'(r_s3_pvm) + t_sum'(r_s3_pgd));
        end
        // lookahead product
        if (w_adv[4]) begin
            r_s5_w   <= r_s4_w;
            r_s5_v   <= r_s4_v;
            r_s5_g1  <= r_s4_g1;
            r_s5_v1  <= r_s4_v1;
            r_s5_pnm <= mul_q16(r_s4_v1, w_mf);
        end
        // step gradient select
        if (w_adv[5]) begin
            r_s6_w <= r_s5_w;
            if (!w_mom_on) begin
                r_s6_vo <= r_s5_v;
                r_s6_g2 <= r_s5_g1;
            end else begin
                r_s6_vo <= r_s5_v1;
                r_s6_g2 <= i_cfg.nest_en ? sat_val(t_sum'(r_s5_g1) + t_sum'(r_s5_pnm))
                                         : r_s5_v1;
            end
        end
        // rate product
        if (w_adv[6]) begin
            r_s7_w  <= r_s6_w;
            r_s7_vo <= r_s6_vo;
            r_s7_pl <= mul_q16(r_s6_g2, {1'b0, i_cfg.lr});
        end
        // weight update, output register
        if (w_adv[7]) begin
            r_s8_wo <= sat_val(t_sum'(r_s7_w) - t_sum'(r_s7_pl));
            r_s8_vo <= r_s7_vo;
        end
    end

    assign o_ready    = w_adv[0];
    assign o_valid    = r_vld[NSTG-1];
    assign o_weight   = r_s8_wo;
    assign o_velocity = r_s8_vo;
    assign o_last     = r_last[NSTG-1];
    assign o_stat.vld = r_vld;
    assign o_stat.adv = w_adv;

endmodule

>>> hw/rtl/sgd_momentum_weight_update_unit.sv
// Eight register stages lie between request acceptance and result valid.
// One request per cycle unless the output stalls; each multiply and add/saturate has a stage.
// Backpressure holds a stage only if all stages from it on are full; empty ones keep filling.
// Reset: i_rst_n synchronous, active low; clears stage valid bits and config registers.
module sgd_momentum_weight_update_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sgdm_pkg::IN_W-1:0]     s_axis_tdata,  // weight_in, gradient_in, velocity_in
    input  logic                          s_axis_tlast,  // last_in
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sgdm_pkg::OUT_W-1:0]    m_axis_tdata,  // weight_out, velocity_out
    output logic                          m_axis_tlast   // last_out
);
    import sgdm_pkg::*;

    t_cfg       w_cfg;
    t_pipe_stat w_stat;
    t_val       w_wo;
    t_val       w_vo;

    sgdm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sgdm_pipe u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_weight   (t_val'(s_axis_tdata[VW-1:0])),
        .i_gradient (t_val'(s_axis_tdata[2*VW-1:VW])),
        .i_velocity (t_val'(s_axis_tdata[3*VW-1:2*VW])),
        .i_last     (s_axis_tlast),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_weight   (w_wo),
        .o_velocity (w_vo),
        .o_last     (m_axis_tlast),
        .o_stat     (w_stat)
    );

    assign m_axis_tdata = OUT_W'({w_vo, w_wo});

`ifndef SYNTHESIS
    // full pipe with stalled output must refuse requests
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_stat.vld) && !m_axis_tready |-> !s_axis_tready)
        else $error("request accepted into a full stalled pipe");

    // input is only refused when the result is stalled
    a_ready_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request refused without output stall");

    // a held next-to-last stage keeps its item
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.vld[NSTG-2] && !w_stat.adv[NSTG-2] |=> w_stat.vld[NSTG-2])
        else $error("stalled stage dropped its item");
`endif

endmodule
